// ===== rtl/core/pau_pkg.sv =====
// Shared types and pixel arithmetic for the 2x pixel-art upscaler.
// No dependencies; imported by every module of the block.
package pau_pkg;

  typedef logic [23:0] pixel_t;

  // Bit 0 of each 8-bit channel, and the two low bits of each channel.
  localparam pixel_t LSB_MASK  = 24'h010101;
  localparam pixel_t LOW2_MASK = 24'h030303;

  // One source column: rows -1, 0, +1, +2 around the center row.
  typedef struct packed {
    logic   line_start;
    pixel_t pixel_above;
    pixel_t pixel_center_row;
    pixel_t pixel_below;
    pixel_t pixel_below_two;
  } col_t;

  // One 2x2 output block.
  typedef struct packed {
    pixel_t top_left;
    pixel_t top_right;
    pixel_t bottom_left;
    pixel_t bottom_right;
  } blk_t;

  // 4x4 source window, named by row: i e f j / g a b k / h c d l / m n o p.
  typedef struct packed {
    pixel_t i, e, f, j;
    pixel_t g, a, b, k;
    pixel_t h, c, d, l;
    pixel_t m, n, o, p;
  } window_t;

  // Per-channel floor((a + b) / 2).
  function automatic pixel_t avg2(pixel_t a, pixel_t b);
    logic [24:0] sum;
    sum = {1'b0, a} + {1'b0, b} - {1'b0, (a ^ b) & LSB_MASK};
    return sum[24:1];
  endfunction

  // Per-channel floor((a + b + c + d) / 4).
  function automatic pixel_t avg4(pixel_t a, pixel_t b, pixel_t c, pixel_t d);
    pixel_t      low;
    logic [25:0] sum;
    // Carries out of a channel's low two bits are masked away.
    low = ((a & LOW2_MASK) + (b & LOW2_MASK) + (c & LOW2_MASK) + (d & LOW2_MASK))
          & LOW2_MASK;
    sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d} - {2'b00, low};
    return sum[25:2];
  endfunction

  // Neighbor vote term: +1 when p misses q or s, -1 when o misses either.
  function automatic logic signed [1:0] vote(pixel_t p, pixel_t o, pixel_t q, pixel_t s);
    logic [1:0]        np;
    logic [1:0]        no;
    logic signed [1:0] r;
    np = 2'd0;
    no = 2'd0;
    if (p == q) np = np + 2'd1;
    else if (o == q) no = no + 2'd1;
    if (p == s) np = np + 2'd1;
    else if (o == s) no = no + 2'd1;
    r = 2'sd0;
    if (np <= 2'd1) r = r + 2'sd1;
    if (no <= 2'd1) r = r - 2'sd1;
    return r;
  endfunction

endpackage

// ===== rtl/core/pau_window.sv =====
// Sliding 4x4 source window and line warm-up tracking.
// Depends on pau_pkg for col_t and window_t.
module pau_window (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             drain,
  input  pau_pkg::col_t    col,
  output pau_pkg::window_t win,
  output logic             loaded
);
  import pau_pkg::*;

  logic [1:0] seen;
  logic [1:0] seen_base;
  logic [1:0] seen_next;
  logic       primed;

  // A line start discards the count of the previous line.
  assign seen_base = col.line_start ? 2'd0 : seen;
  assign primed    = (seen_base == 2'd3);
  assign seen_next = primed ? seen_base : seen_base + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= 2'd0;
      loaded <= 1'b0;
    end else if (take) begin
      seen   <= seen_next;
      loaded <= primed;
    end else if (drain) begin
      loaded <= 1'b0;
    end
  end

  // Shift every row one column left, new column enters on the right.
  always_ff @(posedge clk) begin
    if (take) begin
      win.i <= win.e;  win.e <= win.f;  win.f <= win.j;  win.j <= col.pixel_above;
      win.g <= win.a;  win.a <= win.b;  win.b <= win.k;  win.k <= col.pixel_center_row;
      win.h <= win.c;  win.c <= win.d;  win.d <= win.l;  win.l <= col.pixel_below;
      win.m <= win.n;  win.n <= win.o;  win.o <= win.p;  win.p <= col.pixel_below_two;
    end
  end

endmodule

// ===== rtl/core/pau_kernel.sv =====
// 2xSaI decision and blending logic for one 4x4 window.
// Depends on pau_pkg for window_t, blk_t and the average/vote functions.
module pau_kernel (
  input  pau_pkg::window_t win,
  output pau_pkg::blk_t    blk
);
  import pau_pkg::*;

  pixel_t            tr;
  pixel_t            bl;
  pixel_t            br;
  pixel_t            ab;
  pixel_t            ac;
  pixel_t            abcd;
  logic signed [3:0] r;

  assign ab   = avg2(win.a, win.b);
  assign ac   = avg2(win.a, win.c);
  assign abcd = avg4(win.a, win.b, win.c, win.d);

  always_comb begin
    r = 4'(vote(win.a, win.b, win.g, win.e)) - 4'(vote(win.b, win.a, win.k, win.f))
      - 4'(vote(win.b, win.a, win.h, win.n)) + 4'(vote(win.a, win.b, win.l, win.o));
  end

  always_comb begin
    tr = ab;
    bl = ac;
    br = abcd;
    if (win.a == win.d && win.b != win.c) begin
      if ((win.a == win.e && win.b == win.l) ||
          (win.a == win.c && win.a == win.f && win.b != win.e && win.b == win.j))
        tr = win.a;
      if ((win.a == win.g && win.c == win.o) ||
          (win.a == win.b && win.a == win.h && win.g != win.c && win.c == win.m))
        bl = win.a;
      br = win.a;
    end else if (win.b == win.c && win.a != win.d) begin
      if ((win.b == win.f && win.a == win.h) ||
          (win.b == win.e && win.b == win.d && win.a != win.f && win.a == win.i))
        tr = win.b;
      if ((win.c == win.h && win.a == win.f) ||
          (win.c == win.g && win.c == win.d && win.a != win.h && win.a == win.i))
        bl = win.c;
      br = win.b;
    end else if (win.a == win.d && win.b == win.c) begin
      if (win.a == win.b) begin
        tr = win.a;
        bl = win.a;
        br = win.a;
      end else if (r > 4'sd0) begin
        br = win.a;
      end else if (r < 4'sd0) begin
        br = win.b;
      end
    end else begin
      if (win.a == win.c && win.a == win.f && win.b != win.e && win.b == win.j)
        tr = win.a;
      else if (win.b == win.e && win.b == win.d && win.a != win.f && win.a == win.i)
        tr = win.b;
      if (win.a == win.b && win.a == win.h && win.g != win.c && win.c == win.m)
        bl = win.a;
      else if (win.c == win.g && win.c == win.d && win.a != win.h && win.a == win.i)
        bl = win.c;
    end
  end

  assign blk.top_left     = win.a;
  assign blk.top_right    = tr;
  assign blk.bottom_left  = bl;
  assign blk.bottom_right = br;

endmodule

// ===== rtl/core/pixel_art_2x_upscaler.sv =====
// A column accepted into the window register passes, as its 2x2 block, into the
// result register, from which the receiver takes it.
// One column per cycle while col_stall is low; one block per column from the fourth
// column of a line on, none for the first three columns.
// The window register is the input stage, the block register the result stage.
// Reset (rst, synchronous) empties both stages and clears the line count.
module pixel_art_2x_upscaler (
  input  logic           clk,
  input  logic           rst,
  input  logic           col_valid,
  output logic           col_stall,
  input  pau_pkg::col_t  col,
  output logic           blk_valid,
  input  logic           blk_stall,
  output pau_pkg::blk_t  blk
);
  import pau_pkg::*;

  window_t win;
  blk_t    blk_next;
  logic    loaded;
  logic    hold;
  logic    take;
  logic    drain;

  // Hold the window while its block cannot move into the result register.
  assign hold      = blk_valid && blk_stall;
  assign col_stall = loaded && hold;
  assign take      = col_valid && !col_stall;
  assign drain     = loaded && !hold;

  pau_window u_window (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .drain  (drain),
    .col    (col),
    .win    (win),
    .loaded (loaded)
  );

  pau_kernel u_kernel (
    .win (win),
    .blk (blk_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (drain) begin
      blk_valid <= 1'b1;
    end else if (!blk_stall) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      blk <= blk_next;
    end
  end

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !blk_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    col_stall |-> (blk_valid && loaded))
    else $error("input stalled without a blocked window");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(blk_valid) |-> $past(loaded))
    else $error("result raised without a loaded window");

  a_line_warmup: assert property (@(posedge clk) disable iff (rst)
    (take && col.line_start) |=> !loaded)
    else $error("window loaded on first column of a line");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for pixel_art_2x_upscaler: feeds source columns, predicts each 2x2
// output block with its own window model, and compares every block field by field.
// Depends on pau_pkg (col_t, blk_t, pixel_t) and the RTL top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pau_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 80;
  localparam int RANDOM_COLS = 320;

  logic   clk;
  logic   rst;
  logic   col_valid;
  logic   col_stall;
  col_t   col_bus;
  logic   blk_valid;
  logic   blk_stall;
  blk_t   blk_bus;

  // Predicted blocks in arrival order.
  blk_t   expected_blocks[$];
  int     errors = 0;
  int     cycles = 0;

  // Window model: three previous columns, oldest first, rows -1..+2.
  pixel_t win[3][4];
  logic [1:0] line_cols;

  bit     tx_idle = 1;
  bit     rx_idle = 1;
  int     hold_ticket = 0;

  pixel_t line_colors[4];
  int     color_count = 4;

  pixel_art_2x_upscaler uut (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .col_stall (col_stall),
    .col       (col_bus),
    .blk_valid (blk_valid),
    .blk_stall (blk_stall),
    .blk       (blk_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Per-channel floor of the mean of two pixels.
  function automatic pixel_t half_mix(pixel_t x, pixel_t y);
    pixel_t r;
    int     s;
    for (int ch = 0; ch < 3; ch++) begin
      s = int'(x[8*ch +: 8]) + int'(y[8*ch +: 8]);
      r[8*ch +: 8] = 8'(s / 2);
    end
    return r;
  endfunction

  // Per-channel floor of the mean of four pixels.
  function automatic pixel_t quad_mix(pixel_t w, pixel_t x, pixel_t y, pixel_t z);
    pixel_t r;
    int     s;
    for (int ch = 0; ch < 3; ch++) begin
      s = int'(w[8*ch +: 8]) + int'(x[8*ch +: 8]) + int'(y[8*ch +: 8]) +
          int'(z[8*ch +: 8]);
      r[8*ch +: 8] = 8'(s / 4);
    end
    return r;
  endfunction

  // Neighbor vote: +1 when mine misses q or s, -1 when other misses either
  // (other only counts where mine fails to match).
  function automatic int neighbor_vote(pixel_t mine, pixel_t other, pixel_t q, pixel_t s);
    int hits_mine;
    int hits_other;
    int score;
    hits_mine  = 0;
    hits_other = 0;
    score      = 0;
    if (mine == q) hits_mine++;
    else if (other == q) hits_other++;
    if (mine == s) hits_mine++;
    else if (other == s) hits_other++;
    if (hits_mine <= 1) score++;
    if (hits_other <= 1) score--;
    return score;
  endfunction

  // Slide one column into the window; return 1 with the block when one is due.
  function automatic bit next_block(input col_t column, output blk_t res);
    bit     ready;
    pixel_t i, e, f, j, g, a, b, k, h, c, d, l, m, n, o;
    pixel_t tr, bl, br;
    int     score;
    if (column.line_start) line_cols = 2'd0;
    ready = (line_cols == 2'd3);
    i = win[0][0]; g = win[0][1]; h = win[0][2]; m = win[0][3];
    e = win[1][0]; a = win[1][1]; c = win[1][2]; n = win[1][3];
    f = win[2][0]; b = win[2][1]; d = win[2][2]; o = win[2][3];
    j = column.pixel_above;
    k = column.pixel_center_row;
    l = column.pixel_below;
    for (int r = 0; r < 4; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
    end
    win[2][0] = column.pixel_above;
    win[2][1] = column.pixel_center_row;
    win[2][2] = column.pixel_below;
    win[2][3] = column.pixel_below_two;
    if (line_cols != 2'd3) line_cols = line_cols + 2'd1;
    res = '0;
    if (!ready) return 1'b0;

    if (a == d && b != c) begin
      if ((a == e && b == l) || (a == c && a == f && b != e && b == j)) tr = a;
      else tr = half_mix(a, b);
      if ((a == g && c == o) || (a == b && a == h && g != c && c == m)) bl = a;
      else bl = half_mix(a, c);
      br = a;
    end else if (b == c && a != d) begin
      if ((b == f && a == h) || (b == e && b == d && a != f && a == i)) tr = b;
      else tr = half_mix(a, b);
      if ((c == h && a == f) || (c == g && c == d && a != h && a == i)) bl = c;
      else bl = half_mix(a, c);
      br = b;
    end else if (a == d && b == c) begin
      if (a == b) begin
        tr = a;
        bl = a;
        br = a;
      end else begin
        tr = half_mix(a, b);
        bl = half_mix(a, c);
        score = neighbor_vote(a, b, g, e) - neighbor_vote(b, a, k, f)
              - neighbor_vote(b, a, h, n) + neighbor_vote(a, b, l, o);
        if (score > 0) br = a;
        else if (score < 0) br = b;
        else br = quad_mix(a, b, c, d);
      end
    end else begin
      br = quad_mix(a, b, c, d);
      if (a == c && a == f && b != e && b == j) tr = a;
      else if (b == e && b == d && a != f && a == i) tr = b;
      else tr = half_mix(a, b);
      if (a == b && a == h && g != c && c == m) bl = a;
      else if (c == g && c == d && a != h && a == i) bl = c;
      else bl = half_mix(a, c);
    end
    res.top_left     = a;
    res.top_right    = tr;
    res.bottom_left  = bl;
    res.bottom_right = br;
    return 1'b1;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int gap_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic col_t make_column(logic ls, pixel_t up, pixel_t ctr, pixel_t dn,
                                       pixel_t dn2);
    col_t column;
    column.line_start       = ls;
    column.pixel_above      = up;
    column.pixel_center_row = ctr;
    column.pixel_below      = dn;
    column.pixel_below_two  = dn2;
    return column;
  endfunction

  function automatic col_t random_column(logic ls);
    return make_column(ls, pixel_t'($urandom), pixel_t'($urandom), pixel_t'($urandom),
                       pixel_t'($urandom));
  endfunction

  // Pixel from the current line's small palette, now and then a fully random one.
  function automatic pixel_t line_pixel();
    if ($urandom_range(0, 15) == 0) return pixel_t'($urandom);
    return line_colors[$urandom_range(0, color_count - 1)];
  endfunction

  // Send one request; entered and left at a falling edge.
  task automatic send_col(input col_t column);
    blk_t res;
    col_bus   = column;
    col_valid = 1'b1;
    do @(posedge clk); while (col_stall);
    if (next_block(column, res)) expected_blocks.push_back(res);
    @(negedge clk);
    col_valid = 1'b0;
    if (tx_idle) repeat (gap_cycles()) @(negedge clk);
  endtask

  task automatic wait_drain();
    while (expected_blocks.size() != 0) @(negedge clk);
  endtask

  // One line of four columns drawn from a 4x4 map of palette indexes,
  // one hex digit per cell, rows -1..+2 from the top.
  task automatic send_pattern(input logic [63:0] cells);
    pixel_t shade[4];
    shade = '{24'h204080, 24'hFFFFFF, 24'h000000, 24'h7F7F01};
    for (int x = 0; x < 4; x++)
      send_col(make_column(x == 0, shade[cells[60 - 4*x +: 2]], shade[cells[44 - 4*x +: 2]],
                           shade[cells[28 - 4*x +: 2]], shade[cells[12 - 4*x +: 2]]));
  endtask

  function automatic void compare_pixel(string field, pixel_t want, pixel_t got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %06h got %06h", $time, field, want, got);
    end
  endfunction

  initial begin : block_checker
    blk_t want;
    forever begin
      @(posedge clk);
      if (!rst && blk_valid && !blk_stall) begin
        if (expected_blocks.size() == 0) begin
          errors++;
          $display("%0t: block expected none got %h", $time, blk_bus);
        end else begin
          want = expected_blocks.pop_front();
          compare_pixel("top_left", want.top_left, blk_bus.top_left);
          compare_pixel("top_right", want.top_right, blk_bus.top_right);
          compare_pixel("bottom_left", want.bottom_left, blk_bus.bottom_left);
          compare_pixel("bottom_right", want.bottom_right, blk_bus.bottom_right);
        end
      end
    end
  end

  // Output side: random stalls, plus a long hold whenever the ticket moves.
  initial begin : block_receiver
    int gap_left  = 0;
    int hold_left = 0;
    int seen      = 0;
    blk_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != seen) begin
        seen      = hold_ticket;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        blk_stall = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        blk_stall = 1'b1;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        gap_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(0, 2);
        blk_stall = 1'b1;
      end else begin
        blk_stall = 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pixel_art_2x_upscaler: mismatch");
    $finish;
  end

  task automatic reset_block();
    for (int x = 0; x < 3; x++)
      for (int r = 0; r < 4; r++) win[x][r] = '0;
    line_cols = 2'd0;
    repeat (7) @(negedge clk);
    rst = 1'b0;
  endtask

  // Field extremes and channel carries in the averages.
  task automatic test_extremes();
    send_col(make_column(1'b1, 24'h000000, 24'h000000, 24'h000000, 24'h000000));
    send_col(make_column(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_col(make_column(1'b0, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000));
    send_col(make_column(1'b0, 24'hAAAAAA, 24'h555555, 24'hFFFFFF, 24'h010101));
    send_col(make_column(1'b0, 24'hFEFEFE, 24'h010101, 24'h000000, 24'hFFFFFF));
    send_col(make_column(1'b0, 24'h000000, 24'hFFFFFF, 24'hFEFEFE, 24'h7F7F7F));
  endtask

  // Restart mid warm-up, back-to-back line starts, then a line that never restarts.
  task automatic test_line_start();
    send_col(random_column(1'b1));
    send_col(random_column(1'b1));
    for (int x = 0; x < 5; x++) send_col(random_column(1'b0));
  endtask

  task automatic test_edge_patterns();
    send_pattern(64'h1200_2120_0220_0000);  // right/lower neighbors equal, corner rules
    send_pattern(64'h0200_2120_0210_0000);  // both diagonals equal, vote favors center
    send_pattern(64'h0012_0120_0130_0000);  // no diagonal, upper right takes center
  endtask

  task automatic test_backpressure();
    tx_idle = 0;
    @(posedge clk);
    hold_ticket++;
    @(negedge clk);
    for (int x = 0; x < 40; x++) send_col(random_column(x == 0));
    // hold the sender until every block is out
    wait_drain();
    for (int x = 0; x < 20; x++) send_col(random_column(1'b0));
    wait_drain();
    tx_idle = 1;
  endtask

  task automatic test_random_lines();
    int   sent;
    int   len;
    col_t column;
    sent = 0;
    while (sent < RANDOM_COLS) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_idle = 0;
        rx_idle = 0;
      end else begin
        tx_idle = 1;
        rx_idle = 1;
      end
      color_count = $urandom_range(2, 4);
      for (int q = 0; q < 4; q++)
        line_colors[q] = ($urandom_range(0, 7) == 0) ?
                         ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000) :
                         pixel_t'($urandom);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      for (int x = 0; x < len; x++) begin
        column = make_column(x == 0, line_pixel(), line_pixel(), line_pixel(), line_pixel());
        // drop or add a line start now and then
        if ($urandom_range(0, 19) == 0) column.line_start = ~column.line_start;
        send_col(column);
      end
      sent += len;
    end
    tx_idle = 1;
    rx_idle = 1;
  endtask

  initial begin
    rst       = 1'b1;
    col_valid = 1'b0;
    col_bus   = '0;
    reset_block();
    test_extremes();
    test_line_start();
    test_edge_patterns();
    test_backpressure();
    test_random_lines();
    wait_drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && expected_blocks.size() == 0)
      $display("pixel_art_2x_upscaler: match");
    else
      $display("pixel_art_2x_upscaler: mismatch");
    $finish;
  end

endmodule
